// ----- sv/assert_macros.svh -----
// Assertion helpers for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is low.
`define AST_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off while reset is low.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bcwt_pkg.sv -----
`default_nettype none

package bcwt_pkg;

    // Request type codes
    localparam logic [3:0] REQ_PIN      = 4'd0;
    localparam logic [3:0] REQ_UNPIN    = 4'd1;
    localparam logic [3:0] REQ_RECYCLE  = 4'd2;
    localparam logic [3:0] REQ_DISCARD  = 4'd3;
    localparam logic [3:0] REQ_EXCHANGE = 4'd4;
    localparam logic [3:0] REQ_CLEAR    = 4'd5;
    localparam logic [3:0] REQ_SET      = 4'd6;
    localparam logic [3:0] REQ_UPDATE   = 4'd7;
    localparam logic [3:0] REQ_SET_IF   = 4'd8;

    // Life status codes
    localparam logic [1:0] STAT_NORMAL    = 2'd0;
    localparam logic [1:0] STAT_RECYCLING = 2'd1;
    localparam logic [1:0] STAT_DISCARDED = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_UNPIN_ZERO = 2'd1;
    localparam logic [1:0] ERR_PIN_MAX   = 2'd2;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [9:0]  slot;
        logic [1:0]  exp_status;
        logic [15:0] exp_ref_count;
        logic [15:0] exp_flags;
        logic [1:0]  new_status;
        logic [15:0] new_ref_count;
        logic [15:0] new_flags;
        logic [15:0] set_mask;
        logic [15:0] clear_mask;
        logic [15:0] cond_mask;
    } t_req;

    typedef struct packed {
        logic        success;
        logic [1:0]  old_status;
        logic [15:0] old_ref_count;
        logic [15:0] old_flags;
        logic [1:0]  error;
    } t_rsp;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MODIFY
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;   // zero one table entry
        logic accept;     // capture request, read its word
        logic commit;     // write back, load result register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;   // clear pointer at the last entry
        logic out_busy;   // result register full and not drained this cycle
    } t_dp_sts;

endpackage

`default_nettype wire

// ----- sv/bcwt_alu.sv -----
`default_nettype none

module bcwt_alu #(
    parameter int REF_BITS  = 16,
    parameter int FLAG_BITS = 16,
    parameter int WORD_W    = 2 + REF_BITS + FLAG_BITS
) (
    input  bcwt_pkg::t_req    i_req,
    input  logic              i_in_range,
    input  logic [WORD_W-1:0] i_word,
    output logic [WORD_W-1:0] o_word,
    output logic              o_we,
    output bcwt_pkg::t_rsp    o_rsp
);
    import bcwt_pkg::*;

    localparam logic [REF_BITS-1:0] CNT_ONE = REF_BITS'(1);

    logic [1:0]           cur_status;
    logic [REF_BITS-1:0]  cur_count;
    logic [FLAG_BITS-1:0] cur_flags;
    logic [1:0]           n_status;
    logic [REF_BITS-1:0]  n_count;
    logic [FLAG_BITS-1:0] n_flags;
    logic [31:0]          cnt_w;
    logic [31:0]          flg_w;
    logic [31:0]          exp_cnt_w;
    logic [31:0]          exp_flg_w;
    logic [31:0]          new_cnt_w;
    logic [31:0]          new_flg_w;
    logic [31:0]          set_w;
    logic [31:0]          clr_w;
    logic [31:0]          cond_w;
    logic [FLAG_BITS-1:0] set_m;
    logic [FLAG_BITS-1:0] clr_m;
    logic                 match_cf;
    logic                 success;
    logic [1:0]           err;

    assign cur_status = i_word[WORD_W-1 -: 2];
    assign cur_count  = i_word[FLAG_BITS +: REF_BITS];
    assign cur_flags  = i_word[FLAG_BITS-1:0];

    // Compare at 32 bits so an expected value too wide for the field never matches
    assign cnt_w     = 32'(cur_count);
    assign flg_w     = 32'(cur_flags);
    assign exp_cnt_w = 32'(i_req.exp_ref_count);
    assign exp_flg_w = 32'(i_req.exp_flags);
    assign new_cnt_w = 32'(i_req.new_ref_count);
    assign new_flg_w = 32'(i_req.new_flags);
    assign set_w     = 32'(i_req.set_mask);
    assign clr_w     = 32'(i_req.clear_mask);
    assign cond_w    = 32'(i_req.cond_mask);
    assign set_m     = set_w[FLAG_BITS-1:0];
    assign clr_m     = clr_w[FLAG_BITS-1:0];
    assign match_cf  = (cnt_w == exp_cnt_w) && (flg_w == exp_flg_w);

    always_comb begin
        n_status = cur_status;
        n_count  = cur_count;
        n_flags  = cur_flags;
        success  = 1'b0;
        err      = ERR_NONE;
        case (i_req.req_type)
            REQ_PIN: begin
                if (cur_status == STAT_NORMAL) begin
                    if (cur_count == {REF_BITS{1'b1}}) begin
                        err = ERR_PIN_MAX;
                    end else begin
                        n_count = cur_count + CNT_ONE;
                        success = 1'b1;
                    end
                end
            end
            REQ_UNPIN: begin
                if (cur_count == '0) begin
                    err = ERR_UNPIN_ZERO;
                end else begin
                    n_count = cur_count - CNT_ONE;
                    n_flags = cur_flags & ~clr_m;
                    success = 1'b1;
                end
            end
            REQ_RECYCLE: begin
                if (cur_status == STAT_NORMAL && match_cf) begin
                    n_status = STAT_RECYCLING;
                    n_count  = '0;
                    n_flags  = '0;
                    success  = 1'b1;
                end
            end
            REQ_DISCARD: begin
                if (cur_status == STAT_RECYCLING && cur_count == '0 && cur_flags == '0) begin
                    n_status = STAT_DISCARDED;
                    n_count  = '0;
                    n_flags  = '0;
                    success  = 1'b1;
                end
            end
            REQ_EXCHANGE: begin
                if (cur_status == i_req.exp_status && match_cf) begin
                    n_status = i_req.new_status;
                    n_count  = new_cnt_w[REF_BITS-1:0];
                    n_flags  = new_flg_w[FLAG_BITS-1:0];
                    success  = 1'b1;
                end
            end
            REQ_CLEAR: begin
                n_flags = cur_flags & ~clr_m;
                success = 1'b1;
            end
            REQ_SET: begin
                n_flags = cur_flags | set_m;
                success = 1'b1;
            end
            REQ_UPDATE: begin
                n_flags = (cur_flags | set_m) & ~clr_m;
                success = 1'b1;
            end
            REQ_SET_IF: begin
                if ((flg_w & cond_w) == 32'd0) begin
                    n_flags = cur_flags | set_m;
                    success = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_word = {n_status, n_count, n_flags};
    assign o_we   = i_in_range;

    always_comb begin
        if (i_in_range) begin
            o_rsp.success       = success;
            o_rsp.old_status    = cur_status;
            o_rsp.old_ref_count = cnt_w[15:0];
            o_rsp.old_flags     = flg_w[15:0];
            o_rsp.error         = err;
        end else begin
            o_rsp = '0;
        end
    end

endmodule

`default_nettype wire

// ----- sv/bcwt_dp.sv -----
`default_nettype none

module bcwt_dp #(
    parameter int NUM_SLOTS = 1024,
    parameter int REF_BITS  = 16,
    parameter int FLAG_BITS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bcwt_pkg::t_dp_cmd i_cmd,
    output bcwt_pkg::t_dp_sts o_sts,
    input  bcwt_pkg::t_req    i_req,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output bcwt_pkg::t_rsp    o_rsp
);
    import bcwt_pkg::*;

    localparam int AW     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int WORD_W = 2 + REF_BITS + FLAG_BITS;
    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_SLOTS - 1);

    logic [WORD_W-1:0] r_mem [NUM_SLOTS];
    logic [WORD_W-1:0] r_rd_word;
    logic [AW-1:0]     r_clr_addr;
    logic [AW-1:0]     n_clr_addr;
    logic [AW-1:0]     r_addr;
    t_req              r_req;
    logic              r_in_range;
    t_rsp              r_rsp;
    logic              r_out_valid;
    logic              n_out_valid;
    logic [16:0]       slot_w;
    logic [AW-1:0]     slot_idx;
    logic              slot_ok;
    logic [WORD_W-1:0] alu_word;
    logic              alu_we;
    t_rsp              alu_rsp;

    assign slot_w   = 17'(i_req.slot);
    assign slot_idx = slot_w[AW-1:0];
    assign slot_ok  = slot_w < 17'(NUM_SLOTS);

    // Clear pointer walks the table once after reset
    assign n_clr_addr = i_cmd.clr_step ? r_clr_addr + AW'(1) : r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else begin
            r_clr_addr <= n_clr_addr;
        end
    end

    // Single write port shared by the clear sweep and write-back
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_cmd.commit && alu_we) begin
            r_mem[r_addr] <= alu_word;
        end
        if (i_cmd.accept) begin
            r_rd_word <= r_mem[slot_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req      <= i_req;
            r_addr     <= slot_idx;
            r_in_range <= slot_ok;
        end
    end

    bcwt_alu #(
        .REF_BITS  (REF_BITS),
        .FLAG_BITS (FLAG_BITS),
        .WORD_W    (WORD_W)
    ) u_alu (
        .i_req      (r_req),
        .i_in_range (r_in_range),
        .i_word     (r_rd_word),
        .o_word     (alu_word),
        .o_we       (alu_we),
        .o_rsp      (alu_rsp)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_rsp <= alu_rsp;
        end
    end

    assign o_sts.clr_last = (r_clr_addr == LAST_ADDR);
    assign o_sts.out_busy = r_out_valid && !i_rsp_ready;
    assign o_rsp_valid    = r_out_valid;
    assign o_rsp          = r_rsp;

endmodule

`default_nettype wire

// ----- sv/bcwt_ctrl.sv -----
`default_nettype none

module bcwt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  bcwt_pkg::t_dp_sts i_sts,
    output bcwt_pkg::t_dp_cmd o_cmd
);
    import bcwt_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_MODIFY;
                end
            end
            S_MODIFY: begin
                if (!i_sts.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
            end
            S_IDLE: begin
                o_req_ready  = 1'b1;
                o_cmd.accept = i_req_valid;
            end
            S_MODIFY: begin
                o_cmd.commit = !i_sts.out_busy;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/buffer_control_word_table_unit.sv -----
`default_nettype none

// Channel   Dir  Handshake                  Payload
// request   in   i_req_valid / o_req_ready  i_req (t_req)
// response  out  o_rsp_valid / i_rsp_ready  o_rsp (t_rsp)
//
// The accept edge reads the addressed word from the table memory into a register;
// then in S_MODIFY, once the response register is free, write-back stores the
// modified word and loads the response. A new request is taken in the cycle
// after write-back. After reset the table is swept to zero, one entry a cycle,
// with o_req_ready low.
// A response stalled on i_rsp_ready holds the next request in write-back until
// the response register drains.

module buffer_control_word_table_unit #(
    parameter int NUM_SLOTS = 1024,
    parameter int REF_BITS  = 16,
    parameter int FLAG_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  bcwt_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output bcwt_pkg::t_rsp o_rsp
);
    import bcwt_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Controller: clear sweep, accept, write-back sequencing
    bcwt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Datapath: table memory, request capture, modify logic, response register
    bcwt_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .REF_BITS  (REF_BITS),
        .FLAG_BITS (FLAG_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

`include "assert_macros.svh"

    // Hold off the next beat until the current one is written back
    `AST_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req_valid && o_req_ready, !o_req_ready, "request accepted while another in flight")
    // Write-back always produces a response beat
    `AST_NEXT(a_commit_resp, i_clk, i_rst_n, w_cmd.commit, o_rsp_valid, "write-back without response")
    // Never overwrite an undelivered response
    `AST_IMP(a_no_overwrite, i_clk, i_rst_n, w_cmd.commit, !(o_rsp_valid && !i_rsp_ready), "response overwritten")
    // Drop no request during the clear sweep
    `AST_IMP(a_clear_blocks, i_clk, i_rst_n, w_cmd.clr_step, !o_req_ready && !w_cmd.commit, "request path active during clear")

endmodule

`default_nettype wire
